// File: rtl/pcag_pkg.sv
// package: shared types and constants of the per-client admission guard
package pcag_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned TokW   = 18;
  localparam int unsigned CntW   = 8;
  localparam int unsigned RateW  = 10;
  localparam int unsigned CfgAddrW = 5;

  localparam logic [TokW-1:0] TokenCost = 18'd1000;

  // register byte addresses
  localparam logic [CfgAddrW-1:0] AddrRefillRate = 5'd0;
  localparam logic [CfgAddrW-1:0] AddrBurst      = 5'd4;
  localparam logic [CfgAddrW-1:0] AddrGetLimit   = 5'd8;
  localparam logic [CfgAddrW-1:0] AddrOtherLimit = 5'd12;
  localparam logic [CfgAddrW-1:0] AddrGlobal     = 5'd16;

  // verdict codes
  localparam logic [1:0] VerdictOk      = 2'd0;
  localparam logic [1:0] VerdictRate    = 2'd1;
  localparam logic [1:0] VerdictConcur  = 2'd2;
  localparam logic [1:0] VerdictBusy    = 2'd3;

  localparam logic OpAdmit   = 1'b0;
  localparam logic OpRelease = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [KeyW-1:0]  requester_id;
    logic             is_get;
    logic             is_api;
    logic [TimeW-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]      verdict;
    logic [CntW-1:0] active_count;
  } rsp_t;

endpackage

// File: rtl/pcag_stream_if.sv
// interface: valid/ready channel carrying one payload item
interface pcag_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/per_client_admission_guard_top.sv
// top level: per-client token bucket and concurrency admission guard
//
//  channel  dir  payload                                        handshake
//  req      in   operation requester_id is_get is_api now_ms    valid/ready
//  rsp      out  verdict active_count                           valid/ready
//  cfg      in   apb-style write/read of five registers         psel/penable
//
// an api admit is checked one table entry per cycle by the shared key
// compare / age compare unit, first in the bucket table, then in the slot
// table, with three steps after each scan; a key match ends a scan early,
// and an admit refused for rate skips the slot scan. an api release scans
// only the slot table; a non-api item goes straight to the global step.
// the refill product uses one multiplier, registered before the add.
// reset clears valid bits and the active count and loads register defaults;
// tables need no clearing pass. req is not ready while an item is in work or
// its result waits in the output register; ready the cycle after it is taken.
module per_client_admission_guard_top #(
  parameter int unsigned CLIENT_ENTRIES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  pcag_stream_if.sink               req_i,
  pcag_stream_if.source             rsp_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pcag_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import pcag_pkg::*;

  localparam int unsigned IdxW = (CLIENT_ENTRIES > 1) ? $clog2(CLIENT_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CLIENT_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_BSCAN, S_BPICK, S_BMUL, S_BADD, S_SSCAN, S_SPICK, S_GLOBAL, S_OUT
  } state_e;

  // configuration registers
  logic [RateW-1:0] refill_rate_q;
  logic [CntW-1:0]  burst_q, get_lim_q, oth_lim_q, gslots_q;

  // tables
  logic [CLIENT_ENTRIES-1:0] bvalid_q, svalid_q;
  logic [KeyW-1:0]  bkey_q   [CLIENT_ENTRIES];
  logic [TokW-1:0]  btok_q   [CLIENT_ENTRIES];
  logic [TimeW-1:0] brefill_q[CLIENT_ENTRIES];
  logic [TimeW-1:0] bseen_q  [CLIENT_ENTRIES];
  logic [KeyW-1:0]  skey_q   [CLIENT_ENTRIES];
  logic [CntW-1:0]  sinfl_q  [CLIENT_ENTRIES];
  logic [TimeW-1:0] sseen_q  [CLIENT_ENTRIES];
  logic [CntW-1:0]  gactive_q;

  state_e           state_q;
  req_t             req_q;
  rsp_t             rsp_q;
  logic             rsp_valid_q;
  logic [IdxW-1:0]  cnt_q;
  logic             hit_q, spare_f_q, vic_f_q;
  logic [IdxW-1:0]  hit_idx_q, spare_q, vic_q;
  logic [TimeW-1:0] oldest_q;
  logic [TokW-1:0]  tok_q;
  logic [TimeW-1:0] rtime_q;
  logic [RateW+TimeW-1:0] prod_q;
  logic             fresh_q;
  logic [1:0]       verdict_q;
  logic             give_q;

  // config port
  assign pready = 1'b1;
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr)
      AddrRefillRate: prdata = 32'(refill_rate_q);
      AddrBurst:      prdata = 32'(burst_q);
      AddrGetLimit:   prdata = 32'(get_lim_q);
      AddrOtherLimit: prdata = 32'(oth_lim_q);
      AddrGlobal:     prdata = 32'(gslots_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refill_rate_q <= 10'd12;
      burst_q       <= 8'd24;
      get_lim_q     <= 8'd3;
      oth_lim_q     <= 8'd1;
      gslots_q      <= 8'd4;
    end else if (cfg_wr) begin
      unique case (paddr)
        AddrRefillRate: refill_rate_q <= pwdata[RateW-1:0];
        AddrBurst:      burst_q       <= pwdata[CntW-1:0];
        AddrGetLimit:   get_lim_q     <= pwdata[CntW-1:0];
        AddrOtherLimit: oth_lim_q     <= pwdata[CntW-1:0];
        AddrGlobal:     gslots_q      <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  // shared scan unit: one entry per cycle
  logic [IdxW-1:0]  idx;
  logic             in_bucket;
  logic             e_valid, e_match, e_cand;
  logic [TimeW-1:0] e_seen;
  assign idx       = cnt_q;
  assign in_bucket = (state_q == S_BSCAN);
  always_comb begin
    e_valid = in_bucket ? bvalid_q[idx] : svalid_q[idx];
    e_match = e_valid && ((in_bucket ? bkey_q[idx] : skey_q[idx]) == req_q.requester_id);
    e_seen  = in_bucket ? bseen_q[idx] : sseen_q[idx];
    e_cand  = e_valid && !e_match && (in_bucket || (sinfl_q[idx] == '0))
              && (!vic_f_q || (e_seen < oldest_q));
  end

  logic [TokW-1:0] cap;
  assign cap = TokW'(burst_q) * TokenCost;

  logic [CntW-1:0] limit;
  assign limit = req_q.is_get ? get_lim_q : oth_lim_q;

  logic [IdxW-1:0] pick_idx;
  logic            pick_ok;
  assign pick_ok  = hit_q || spare_f_q || vic_f_q;
  assign pick_idx = hit_q ? hit_idx_q : (spare_f_q ? spare_q : vic_q);

  logic [RateW+TimeW:0] tsum;
  assign tsum = (RateW+TimeW+1)'(tok_q) + (RateW+TimeW+1)'(prod_q);

  logic scan_end;
  assign scan_end = (cnt_q == LastIdx);

  assign req_i.ready   = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  // sequencer and table updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      bvalid_q    <= '0;
      svalid_q    <= '0;
      gactive_q   <= '0;
      cnt_q       <= '0;
    end else begin
      if (rsp_valid_q && rsp_o.ready) rsp_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid && req_i.ready) begin
            req_q     <= req_i.payload;
            cnt_q     <= '0;
            hit_q     <= 1'b0;
            spare_f_q <= 1'b0;
            vic_f_q   <= 1'b0;
            verdict_q <= VerdictOk;
            give_q    <= 1'b0;
            if (!req_i.payload.is_api) state_q <= S_GLOBAL;
            else if (req_i.payload.operation == OpRelease) state_q <= S_SSCAN;
            else state_q <= S_BSCAN;
          end
        end
        S_BSCAN, S_SSCAN: begin
          if (e_match) begin
            hit_q <= 1'b1; hit_idx_q <= idx;
          end else if (!e_valid && !spare_f_q) begin
            spare_f_q <= 1'b1; spare_q <= idx;
          end else if (e_cand) begin
            vic_f_q <= 1'b1; vic_q <= idx; oldest_q <= e_seen;
          end
          if (e_match || scan_end) state_q <= in_bucket ? S_BPICK : S_SPICK;
          else cnt_q <= cnt_q + 1'b1;
        end
        S_BPICK: begin
          if (!pick_ok) begin
            verdict_q <= VerdictRate; state_q <= S_GLOBAL;
          end else begin
            hit_idx_q <= pick_idx;
            fresh_q   <= !hit_q;
            tok_q     <= hit_q ? btok_q[pick_idx] : cap;
            rtime_q   <= hit_q ? brefill_q[pick_idx] : req_q.now_ms;
            state_q   <= S_BMUL;
          end
        end
        S_BMUL: begin
          prod_q  <= (req_q.now_ms - rtime_q) * refill_rate_q;
          state_q <= S_BADD;
        end
        S_BADD: begin
          logic [TokW-1:0] t;
          t = tok_q;
          if (req_q.now_ms > rtime_q) begin
            t = (tsum > (RateW+TimeW+1)'(cap)) ? cap : tsum[TokW-1:0];
            brefill_q[hit_idx_q] <= req_q.now_ms;
          end else if (fresh_q) begin
            brefill_q[hit_idx_q] <= req_q.now_ms;
          end
          bvalid_q[hit_idx_q] <= 1'b1;
          bkey_q[hit_idx_q]   <= req_q.requester_id;
          bseen_q[hit_idx_q]  <= req_q.now_ms;
          if (t < TokenCost) begin
            btok_q[hit_idx_q] <= t;
            verdict_q <= VerdictRate;
            state_q   <= S_GLOBAL;
          end else begin
            btok_q[hit_idx_q] <= t - TokenCost;
            cnt_q     <= '0;
            hit_q     <= 1'b0;
            spare_f_q <= 1'b0;
            vic_f_q   <= 1'b0;
            state_q   <= S_SSCAN;
          end
        end
        S_SPICK: begin
          if (req_q.operation == OpRelease) begin
            if (hit_q) begin
              if (sinfl_q[hit_idx_q] != '0) sinfl_q[hit_idx_q] <= sinfl_q[hit_idx_q] - 1'b1;
              sseen_q[hit_idx_q] <= req_q.now_ms;
            end
            state_q <= S_GLOBAL;
          end else if (!pick_ok) begin
            verdict_q <= VerdictConcur; state_q <= S_GLOBAL;
          end else begin
            logic [CntW-1:0] n;
            n = hit_q ? sinfl_q[pick_idx] : '0;
            svalid_q[pick_idx] <= 1'b1;
            skey_q[pick_idx]   <= req_q.requester_id;
            sseen_q[pick_idx]  <= req_q.now_ms;
            hit_idx_q          <= pick_idx;
            if (n >= limit) begin
              sinfl_q[pick_idx] <= n;
              verdict_q <= VerdictConcur;
            end else begin
              sinfl_q[pick_idx] <= n + 1'b1;
              give_q <= 1'b1;
            end
            state_q <= S_GLOBAL;
          end
        end
        S_GLOBAL: begin
          logic [1:0]      v;
          logic [CntW-1:0] act;
          v   = verdict_q;
          act = gactive_q;
          if (req_q.operation == OpRelease) begin
            if (gactive_q != '0) act = gactive_q - 1'b1;
          end else if (verdict_q == VerdictOk) begin
            if (gactive_q >= gslots_q) begin
              v = VerdictBusy;
              // busy api request hands its slot back
              if (give_q) sinfl_q[hit_idx_q] <= sinfl_q[hit_idx_q] - 1'b1;
            end else begin
              act = gactive_q + 1'b1;
            end
          end
          gactive_q <= act;
          rsp_q     <= '{verdict: v, active_count: act};
          state_q   <= S_OUT;
        end
        S_OUT: begin
          rsp_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // checks
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> (state_q == S_IDLE)) else $error("ready outside idle");
  a_active_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GLOBAL && req_q.operation == OpAdmit && verdict_q == VerdictOk
     && gactive_q < gslots_q) |=> (gactive_q == $past(gactive_q) + 1'b1))
    else $error("active count not bumped");
  a_rsp_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> rsp_valid_q) else $error("result lost");
endmodule
